[rtl/assert_macros.svh]
// Assertion macros used by the checker file icp_checker.sv.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/icp_pkg.sv]
// Package for the infix-to-postfix converter: sizes, token and entry codes,
// result kinds, FSM types and the precedence function. No dependencies.
package icp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // token classes
  localparam logic [2:0] FUNC_OPERAND  = 3'd0;
  localparam logic [2:0] FUNC_OPERATOR = 3'd1;
  localparam logic [2:0] FUNC_LPAREN   = 3'd2;
  localparam logic [2:0] FUNC_RPAREN   = 3'd3;

  // operator codes, and the stack entry code for a left paren
  localparam logic [2:0] OP_PLUS    = 3'd0;
  localparam logic [2:0] OP_MINUS   = 3'd1;
  localparam logic [2:0] OP_TIMES   = 3'd2;
  localparam logic [2:0] OP_DIVIDE  = 3'd3;
  localparam logic [2:0] OP_POWER   = 3'd4;
  localparam logic [2:0] ENT_LPAREN = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_OPERAND  = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  // token counter saturation point
  localparam logic [1:0] TOK_SAT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_RD,
    ST_POP,
    ST_LAST,
    ST_STAT
  } icp_state_t;

  typedef enum logic [1:0] {
    MODE_OPER,
    MODE_RPAR,
    MODE_FLUSH
  } icp_mode_t;

  function automatic logic [1:0] op_prec(logic [2:0] code);
    logic [1:0] p;
    case (code) inside
      OP_POWER:            p = 2'd3;
      OP_TIMES, OP_DIVIDE: p = 2'd2;
      default:             p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/infix_to_postfix_converter_unit.sv]
// Infix-to-postfix converter, shunting-yard order, operator stack in a synchronous RAM.
// Sequence: a token is latched in ST_IDLE and an operand result is registered from ST_DISP;
//   each popped operator passes ST_RD (stack RAM read), then ST_POP (compare/emit),
//   and the status result is registered from ST_STAT. tok_stall holds off a new token
//   until the FSM is back in ST_IDLE; the synchronous RAM read sets the ST_RD step per pop.
// Reset: synchronous, clears FSM, stack count, token count, error flag and result valid.
module infix_to_postfix_converter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tok_valid,
  output logic                               tok_stall,
  input  logic [2:0]                         func,
  input  logic [2:0]                         op_code,
  input  logic signed [icp_pkg::VALUE_WIDTH-1:0] operand_value,
  input  logic                               last_token,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [1:0]                         out_kind,
  output logic [2:0]                         out_op,
  output logic signed [icp_pkg::VALUE_WIDTH-1:0] out_value,
  output logic                               error,
  output logic                               end_of_expr
);
  import icp_pkg::*;

  icp_state_t state, state_next;
  icp_mode_t  mode, mode_next;

  logic [CNT_W-1:0] count;
  logic [1:0]       tcount;
  logic             err_flag;

  // latched token
  logic [2:0]                    tfunc;
  logic [2:0]                    topc;
  logic signed [VALUE_WIDTH-1:0] tval;
  logic                          tlast;
  logic                          tfirst;

  // stack RAM
  logic [2:0]       stack_mem [STACK_DEPTH];
  logic [2:0]       mem_q;
  logic [CNT_W-1:0] count_dec;
  logic [SP_W-1:0]  rd_idx;

  // decode
  logic       tok_xfer;
  logic       out_free;
  logic       stack_empty;
  logic       stack_full;
  logic       tok_is_oper;
  logic       top_lp;
  logic       pop_more;
  logic [1:0] top_prec;
  logic [1:0] tok_prec;

  // actions
  logic       emit;
  logic [1:0] emit_kind;
  logic [2:0] emit_op;
  logic       push_en;
  logic [2:0] push_code;
  logic       pop_en;
  logic       err_set;
  logic       clear_all;

  assign tok_stall = (state != ST_IDLE);
  assign tok_xfer  = tok_valid && !tok_stall;
  assign out_free  = !res_valid || !res_stall;

  assign count_dec   = count - CNT_W'(1);
  assign rd_idx      = count_dec[SP_W-1:0];
  assign stack_empty = (count == '0);
  assign stack_full  = (count == CNT_W'(STACK_DEPTH));

  assign tok_is_oper = (tfunc == FUNC_OPERATOR) && (topc <= OP_POWER);
  assign top_lp      = (mem_q == ENT_LPAREN);
  assign top_prec    = op_prec(mem_q);
  assign tok_prec    = op_prec(topc);
  // pop while stacked op binds tighter, or equal and left-associative
  assign pop_more    = !top_lp &&
                       ((top_prec > tok_prec) || ((top_prec == tok_prec) && (mem_q != OP_POWER)));

  // RAM: read address tracks the top every cycle; ST_RD writes only on an empty stack and then
  // goes to ST_LAST, not ST_POP, so mem_q in ST_POP always reflects the current top.
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[count[SP_W-1:0]] <= push_code;
    end
    mem_q <= stack_mem[rd_idx];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tok_valid) state_next = ST_DISP;
      end
      ST_DISP: begin
        if (err_flag) begin
          state_next = ST_LAST;
        end else if (tfunc == FUNC_OPERAND) begin
          state_next = out_free ? ST_LAST : ST_DISP;
        end else if (tok_is_oper) begin
          state_next = tfirst ? ST_LAST : ST_RD;
        end else if (tfunc == FUNC_RPAREN) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_LAST;
        end
      end
      ST_RD: begin
        if (stack_empty) state_next = (mode == MODE_FLUSH) ? ST_STAT : ST_LAST;
        else             state_next = ST_POP;
      end
      ST_POP: begin
        unique case (mode)
          MODE_OPER: begin
            if (!pop_more)     state_next = ST_LAST;
            else if (out_free) state_next = ST_RD;
          end
          MODE_RPAR: begin
            if (top_lp)        state_next = ST_LAST;
            else if (out_free) state_next = ST_RD;
          end
          MODE_FLUSH: begin
            if (top_lp)        state_next = ST_STAT;
            else if (out_free) state_next = ST_RD;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_LAST: begin
        if (!tlast)                              state_next = ST_IDLE;
        else if ((tcount != TOK_SAT) || err_flag) state_next = ST_STAT;
        else                                     state_next = ST_RD;
      end
      ST_STAT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // actions
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_OPERAND;
    emit_op   = OP_PLUS;
    push_en   = 1'b0;
    push_code = topc;
    pop_en    = 1'b0;
    err_set   = 1'b0;
    clear_all = 1'b0;
    mode_next = mode;
    unique case (state)
      ST_IDLE: ;
      ST_DISP: begin
        if (!err_flag) begin
          if (tfunc == FUNC_OPERAND) begin
            emit = out_free;
          end else if (tok_is_oper) begin
            if (tfirst) err_set = 1'b1;
            else        mode_next = MODE_OPER;
          end else if (tfunc == FUNC_LPAREN) begin
            push_code = ENT_LPAREN;
            push_en   = !stack_full;
            err_set   = stack_full;
          end else if (tfunc == FUNC_RPAREN) begin
            mode_next = MODE_RPAR;
          end else begin
            err_set = 1'b1;
          end
        end
      end
      ST_RD: begin
        if (stack_empty) begin
          if (mode == MODE_OPER) push_en = 1'b1;
          else if (mode == MODE_RPAR) err_set = 1'b1;
        end
      end
      ST_POP: begin
        emit_kind = KIND_OPERATOR;
        emit_op   = mem_q;
        unique case (mode)
          MODE_OPER: begin
            if (pop_more) begin
              emit   = out_free;
              pop_en = out_free;
            end else begin
              push_en = !stack_full;
              err_set = stack_full;
            end
          end
          MODE_RPAR: begin
            if (top_lp) begin
              pop_en = 1'b1;
            end else begin
              emit   = out_free;
              pop_en = out_free;
            end
          end
          MODE_FLUSH: begin
            if (top_lp) begin
              err_set = 1'b1;
            end else begin
              emit   = out_free;
              pop_en = out_free;
            end
          end
          default: ;
        endcase
      end
      ST_LAST: begin
        if (tlast) begin
          if (tcount != TOK_SAT) err_set = 1'b1;
          mode_next = MODE_FLUSH;
        end
      end
      ST_STAT: begin
        emit_kind = KIND_STATUS;
        emit      = out_free;
        clear_all = out_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= MODE_OPER;
      count    <= '0;
      tcount   <= '0;
      err_flag <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (clear_all)    count <= '0;
      else if (push_en) count <= count + CNT_W'(1);
      else if (pop_en)  count <= count_dec;
      if (clear_all)                              tcount <= '0;
      else if (tok_xfer && (tcount != TOK_SAT))   tcount <= tcount + 2'd1;
      if (clear_all)    err_flag <= 1'b0;
      else if (err_set) err_flag <= 1'b1;
    end
  end

  // token capture
  always_ff @(posedge clk) begin
    if (tok_xfer) begin
      tfunc  <= func;
      topc   <= op_code;
      tval   <= operand_value;
      tlast  <= last_token;
      tfirst <= (tcount == '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind    <= emit_kind;
      out_op      <= (emit_kind == KIND_OPERATOR) ? emit_op : OP_PLUS;
      out_value   <= (emit_kind == KIND_OPERAND) ? tval : '0;
      error       <= (emit_kind == KIND_STATUS) && err_flag;
      end_of_expr <= (emit_kind == KIND_STATUS);
    end
  end

endmodule

[rtl/icp_checker.sv]
// Port-level checker for infix_to_postfix_converter_unit, attached by bind.
// Depends on icp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module icp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               tok_valid,
  input logic                               tok_stall,
  input logic [2:0]                         func,
  input logic [2:0]                         op_code,
  input logic signed [icp_pkg::VALUE_WIDTH-1:0] operand_value,
  input logic                               last_token,
  input logic                               res_valid,
  input logic                               res_stall,
  input logic [1:0]                         out_kind,
  input logic [2:0]                         out_op,
  input logic signed [icp_pkg::VALUE_WIDTH-1:0] out_value,
  input logic                               error,
  input logic                               end_of_expr
);
  import icp_pkg::*;

  // stalled result holds
  `ASSERT_NXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(out_kind) && $stable(out_op) && $stable(out_value))
  // end marker only on status, and status always carries it
  `ASSERT_IMP(a_eoe_status, clk, rst, res_valid && end_of_expr, out_kind == KIND_STATUS)
  `ASSERT_IMP(a_status_eoe, clk, rst, res_valid && (out_kind == KIND_STATUS), end_of_expr)
  // error is reported only on the status result
  `ASSERT_IMP(a_err_eoe, clk, rst, res_valid && error, end_of_expr)
  // one token at a time: after a transfer the token side is held off
  `ASSERT_NXT(a_tok_busy, clk, rst, tok_valid && !tok_stall, tok_stall)

endmodule

bind infix_to_postfix_converter_unit icp_checker u_icp_checker (.*);
